// ===== hw/rtl/scnh_pkg.sv =====
// ----------------------------------------------------------------------------
// scnh_pkg
// Shared types and constants of the sparse count-nonzero histogram.
// ----------------------------------------------------------------------------
package scnh_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_COUNT_DEPTH = 4096;
   localparam int DEF_COUNT_WIDTH = 32;

   // Coordinate fold limits
   localparam int MAX_DIMS     = 4;
   localparam int COORD_FIELDS = 4;
   localparam int DIMS_LIMIT   = (MAX_DIMS < COORD_FIELDS) ? MAX_DIMS : COORD_FIELDS;

   // Action codes
   localparam logic [1:0] ACT_COUNT = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_KEPT_DIMS = 2'd0;
   localparam logic [1:0] CSR_SIZE_DIM1 = 2'd1;
   localparam logic [1:0] CSR_SIZE_DIM2 = 2'd2;
   localparam logic [1:0] CSR_SIZE_DIM3 = 2'd3;

   // Register reset values
   localparam logic [2:0]  RST_KEPT_DIMS = 3'd2;
   localparam logic [15:0] RST_SIZE_DIM1 = 16'd64;
   localparam logic [15:0] RST_SIZE_DIM2 = 16'd1;
   localparam logic [15:0] RST_SIZE_DIM3 = 16'd1;

   // Input transaction
   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        coord_0;
      logic [15:0]        coord_1;
      logic [15:0]        coord_2;
      logic [15:0]        coord_3;
      logic signed [31:0] entry_value;
      logic [11:0]        read_slot;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [31:0] count;
      logic        status;
   } rsp_type;

   // Fold unit status toward the controller
   typedef struct packed {
      logic done;
      logic in_range;
   } fold_res_type;

   typedef enum logic [1:0] {
      FOLD_IDLE,
      FOLD_MUL,
      FOLD_ADD,
      FOLD_DONE
   } fold_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FOLD,
      ST_RMW,
      ST_CLEAR
   } ctrl_state_type;

endpackage

// ===== hw/rtl/scnh_fold.sv =====
// ----------------------------------------------------------------------------
// scnh_fold
// Iterative Horner fold of the kept coordinates into a linear slot position,
// one multiply and one add/range check per kept dimension beyond the first.
// ----------------------------------------------------------------------------
module scnh_fold
   import scnh_pkg::*;
#(
   parameter int COUNT_DEPTH = DEF_COUNT_DEPTH,
   localparam int AW = $clog2(COUNT_DEPTH)
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [15:0]  coord_0,
   input  logic [15:0]  coord_1,
   input  logic [15:0]  coord_2,
   input  logic [15:0]  coord_3,
   input  logic [2:0]   kept_dims,
   input  logic [15:0]  size_dim1,
   input  logic [15:0]  size_dim2,
   input  logic [15:0]  size_dim3,
   output fold_res_type res,
   output logic [AW-1:0] pos
);

   localparam int PW = AW + 16;
   localparam int SW = AW + 17;

   fold_state_type state_ff, state_in;

   logic [AW-1:0] pos_ff;
   logic [PW-1:0] prod_ff;
   logic          inside_ff;
   logic [2:0]    step_ff;
   logic [2:0]    kept_ff;
   logic [15:0]   coord1_ff, coord2_ff, coord3_ff;

   logic [2:0]    eff_k;
   logic          first_out;
   logic [15:0]   ext_sel;
   logic [15:0]   coord_sel;
   logic [SW-1:0] sum;
   logic          sum_out;
   logic [2:0]    step_next;

   // Clamp the kept dimension count into 1..DIMS_LIMIT
   always_comb begin
      if (kept_dims == 3'd0) begin
         eff_k = 3'd1;
      end else if (kept_dims > 3'(DIMS_LIMIT)) begin
         eff_k = 3'(DIMS_LIMIT);
      end else begin
         eff_k = kept_dims;
      end
   end

   assign first_out = 32'(coord_0) >= 32'(COUNT_DEPTH);

   // Operand selection for the current step
   always_comb begin
      case (step_ff[1:0])
         2'd1: begin
            ext_sel   = size_dim1;
            coord_sel = coord1_ff;
         end
         2'd2: begin
            ext_sel   = size_dim2;
            coord_sel = coord2_ff;
         end
         2'd3: begin
            ext_sel   = size_dim3;
            coord_sel = coord3_ff;
         end
         default: begin
            ext_sel   = 16'd0;
            coord_sel = 16'd0;
         end
      endcase
   end

   assign sum       = SW'(prod_ff) + SW'(coord_sel);
   assign sum_out   = sum >= SW'(COUNT_DEPTH);
   assign step_next = step_ff + 3'd1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FOLD_IDLE: begin
            if (start) begin
               if (first_out || eff_k == 3'd1) begin
                  state_in = FOLD_DONE;
               end else begin
                  state_in = FOLD_MUL;
               end
            end
         end
         FOLD_MUL: begin
            state_in = FOLD_ADD;
         end
         FOLD_ADD: begin
            if (sum_out || step_next == kept_ff) begin
               state_in = FOLD_DONE;
            end else begin
               state_in = FOLD_MUL;
            end
         end
         FOLD_DONE: begin
            state_in = FOLD_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      res.done     = state_ff == FOLD_DONE;
      res.in_range = inside_ff;
      pos          = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FOLD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath: one multiply per step, registered before the add
   always_ff @(posedge clock) begin
      unique case (state_ff)
         FOLD_IDLE: begin
            if (start) begin
               pos_ff    <= AW'(coord_0);
               inside_ff <= !first_out;
               step_ff   <= 3'd1;
               kept_ff   <= eff_k;
               coord1_ff <= coord_1;
               coord2_ff <= coord_2;
               coord3_ff <= coord_3;
            end
         end
         FOLD_MUL: begin
            prod_ff <= PW'(pos_ff) * PW'(ext_sel);
         end
         FOLD_ADD: begin
            if (sum_out) begin
               inside_ff <= 1'b0;
            end else begin
               pos_ff <= AW'(sum);
            end
            step_ff <= step_next;
         end
         FOLD_DONE: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/sparse_count_nonzero_histogram.sv =====
// ----------------------------------------------------------------------------
// sparse_count_nonzero_histogram
// Counts nonzero sparse tensor entries per row-major slot in a count memory.
// ----------------------------------------------------------------------------
// One transaction is taken at a time: start is accepted while busy is low and
// the single result is registered onto rsp_strobe, high for exactly one
// cycle; the receiver cannot stall it. A count transaction keeps busy high
// through one multiply and one add per extra kept dimension in the fold unit,
// then the read-modify-write of the count memory, which is skipped when the
// position falls outside it. A read keeps busy through its read-modify-write
// state, an out-of-range read or an unused action not at all. A clear answers
// at once and then sweeps the memory one entry per cycle, busy until the sweep
// ends; the same sweep runs after reset, so the first transaction is taken
// only once it has finished. Register writes are taken in any cycle.
// ----------------------------------------------------------------------------
module sparse_count_nonzero_histogram
   import scnh_pkg::*;
#(
   parameter int COUNT_DEPTH = DEF_COUNT_DEPTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(COUNT_DEPTH);

   // Configuration registers
   logic [2:0]  kept_dims_ff;
   logic [15:0] size_dim1_ff, size_dim2_ff, size_dim3_ff;

   // Control
   ctrl_state_type state_ff, state_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic           clr_last;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   // Captured transaction
   logic [1:0]     op_ff;
   logic           nonzero_ff;
   logic [AW-1:0]  addr_ff, addr_in;

   // Count memory
   logic [COUNT_WIDTH-1:0] count_mem [COUNT_DEPTH];
   logic [COUNT_WIDTH-1:0] mem_rdata_ff;
   logic                   mem_re, mem_we;
   logic [AW-1:0]          mem_raddr, mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   logic                   accept;
   logic                   slot_out;
   logic                   value_nz;
   logic                   fold_start;
   fold_res_type           fold_res;
   logic [AW-1:0]          fold_pos;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [63:0]            new_count_wide;
   logic [63:0]            rd_count_wide;

   assign accept   = start && !busy;
   assign slot_out = 32'(req_data.read_slot) >= 32'(COUNT_DEPTH);
   assign value_nz = req_data.entry_value != 32'sd0;
   assign clr_last = clr_addr_ff == AW'(COUNT_DEPTH - 1);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kept_dims_ff <= RST_KEPT_DIMS;
         size_dim1_ff <= RST_SIZE_DIM1;
         size_dim2_ff <= RST_SIZE_DIM2;
         size_dim3_ff <= RST_SIZE_DIM3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEPT_DIMS: kept_dims_ff <= csr_wdata[2:0];
            CSR_SIZE_DIM1: size_dim1_ff <= csr_wdata;
            CSR_SIZE_DIM2: size_dim2_ff <= csr_wdata;
            CSR_SIZE_DIM3: size_dim3_ff <= csr_wdata;
         endcase
      end
   end

   // Position fold
   scnh_fold #(
      .COUNT_DEPTH (COUNT_DEPTH)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .start     (fold_start),
      .coord_0   (req_data.coord_0),
      .coord_1   (req_data.coord_1),
      .coord_2   (req_data.coord_2),
      .coord_3   (req_data.coord_3),
      .kept_dims (kept_dims_ff),
      .size_dim1 (size_dim1_ff),
      .size_dim2 (size_dim2_ff),
      .size_dim3 (size_dim3_ff),
      .res       (fold_res),
      .pos       (fold_pos)
   );

   // Saturating increment of the count read back
   always_comb begin
      if (op_ff == ACT_COUNT && nonzero_ff && mem_rdata_ff != {COUNT_WIDTH{1'b1}}) begin
         new_count = mem_rdata_ff + COUNT_WIDTH'(1);
      end else begin
         new_count = mem_rdata_ff;
      end
      new_count_wide = 64'(new_count);
      rd_count_wide  = 64'(mem_rdata_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_COUNT: state_in = ST_FOLD;
                  ACT_READ:  state_in = slot_out ? ST_IDLE : ST_RMW;
                  ACT_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FOLD: begin
            if (fold_res.done) begin
               state_in = fold_res.in_range ? ST_RMW : ST_IDLE;
            end
         end
         ST_RMW: begin
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Outputs and memory port control
   always_comb begin
      busy          = state_ff != ST_IDLE;
      fold_start    = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = AW'(req_data.read_slot);
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = new_count;
      addr_in       = addr_ff;
      clr_addr_in   = clr_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_COUNT: begin
                     fold_start = 1'b1;
                  end
                  ACT_READ: begin
                     if (slot_out) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = 1'b1;
                     end else begin
                        mem_re  = 1'b1;
                        addr_in = AW'(req_data.read_slot);
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_FOLD: begin
            mem_raddr = fold_pos;
            if (fold_res.done) begin
               if (fold_res.in_range) begin
                  mem_re  = 1'b1;
                  addr_in = fold_pos;
               end else begin
                  rsp_strobe_in      = 1'b1;
                  rsp_data_in.status = nonzero_ff;
               end
            end
         end
         ST_RMW: begin
            mem_we        = op_ff == ACT_COUNT;
            rsp_strobe_in = 1'b1;
            if (op_ff == ACT_COUNT) begin
               rsp_data_in.count = new_count_wide[31:0];
            end else begin
               rsp_data_in.count = rd_count_wide[31:0];
            end
         end
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_last ? '0 : clr_addr_ff + AW'(1);
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Transaction and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_data.action;
         nonzero_ff <= value_nz;
      end
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Count memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= count_mem[mem_raddr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Checks
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == ACT_READ && !slot_out |-> ##2 rsp_strobe)
      else $error("in-range read gave no result");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we)
      else $error("count memory written while idle");

   a_fold_owned: assert property (@(posedge clock) disable iff (reset)
      fold_res.done |-> state_ff == ST_FOLD)
      else $error("fold finished outside a count transaction");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status |-> rsp_data.count == 32'd0)
      else $error("dropped transaction reported a nonzero count");

   a_clear_wrap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR && clr_last |=> clr_addr_ff == '0)
      else $error("clear sweep did not return to slot zero");

endmodule

// ===== tb/sparse_count_nonzero_histogram_test.sv =====
// ----------------------------------------------------------------------------
// sparse_count_nonzero_histogram_test
// Self-checking bench for the sparse count-nonzero histogram.
// ----------------------------------------------------------------------------
// A behavioral model of the Horner fold and the count memory predicts every
// result when a transaction is accepted. A monitor compares each strobed result
// field by field against the oldest prediction. Directed transactions cover the
// edge cases of the fold and the actions. Random traffic then runs under
// several fold settings and three sender idle profiles.
// ----------------------------------------------------------------------------
module sparse_count_nonzero_histogram_test;
   import scnh_pkg::*;

   localparam int              COUNT_DEPTH       = DEF_COUNT_DEPTH;
   localparam int              COUNT_WIDTH       = DEF_COUNT_WIDTH;
   localparam int              SLOT_BITS         = $clog2(COUNT_DEPTH);
   localparam logic [1:0]      ACT_NONE          = 2'd3;
   localparam longint unsigned CYCLE_LIMIT       = 2000000;
   localparam int              ITEMS_PER_SETTING = 150;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   sparse_count_nonzero_histogram dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Model of the count memory and the fold registers
   logic [COUNT_WIDTH-1:0] model_counts [COUNT_DEPTH];
   logic [2:0]             model_kept_dims;
   logic [15:0]            model_extent [1:3];
   int unsigned            last_hit_slot;
   req_type                last_count_item;

   rsp_type                results_due [$];
   int unsigned            mismatch_count = 0;
   longint unsigned        cycle_count = 0;

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Effective number of folded coordinates
   function automatic int unsigned fold_dims();
      int unsigned dims;
      dims = model_kept_dims;
      if (dims < 1) dims = 1;
      if (dims > DIMS_LIMIT) dims = DIMS_LIMIT;
      return dims;
   endfunction

   // Predicts one transaction and updates the model memory
   function automatic rsp_type histogram_step(req_type item);
      rsp_type              res;
      logic [15:0]          coord [4];
      int unsigned          dims;
      longint unsigned      pos;
      bit                   in_store;
      logic [SLOT_BITS-1:0] slot;
      res.count  = '0;
      res.status = 1'b0;
      coord[0] = item.coord_0;
      coord[1] = item.coord_1;
      coord[2] = item.coord_2;
      coord[3] = item.coord_3;
      case (item.action)
         ACT_COUNT: begin
            dims     = fold_dims();
            pos      = coord[0];
            in_store = pos < COUNT_DEPTH;
            // range check after every Horner step
            for (int i = 1; i < dims && in_store; i++) begin
               pos      = pos * model_extent[i] + coord[i];
               in_store = pos < COUNT_DEPTH;
            end
            if (!in_store) begin
               res.status = (item.entry_value != 0);
            end else begin
               slot = SLOT_BITS'(pos);
               if (item.entry_value != 0 && model_counts[slot] != '1)
                  model_counts[slot] = model_counts[slot] + 1'b1;
               res.count     = model_counts[slot];
               last_hit_slot = 32'(slot);
            end
         end
         ACT_READ: begin
            if (item.read_slot >= COUNT_DEPTH) res.status = 1'b1;
            else                               res.count  = model_counts[item.read_slot];
         end
         ACT_CLEAR: begin
            foreach (model_counts[i]) model_counts[i] = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s at cycle %0d: expected %0h, got %0h",
                  what, cycle_count, want, got);
   endfunction

   // Result monitor: every strobe consumes the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (results_due.size() == 0) begin
            note_mismatch("unexpected result count", '0, rsp_data.count);
         end else begin
            want = results_due.pop_front();
            if (rsp_data.count !== want.count)
               note_mismatch("count", want.count, rsp_data.count);
            if (rsp_data.status !== want.status)
               note_mismatch("status", 32'(want.status), 32'(rsp_data.status));
         end
      end
   end

   // Presents one transaction and holds it until it is taken
   task automatic send_item(input req_type item);
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      results_due.push_back(histogram_step(item));
   endtask

   // Sender idles in each cycle with the given probability
   task automatic idle_gap(input int unsigned pct);
      while ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Holds off until every result is in and the block is idle
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_KEPT_DIMS: model_kept_dims = value[2:0];
         CSR_SIZE_DIM1: model_extent[1] = value;
         CSR_SIZE_DIM2: model_extent[2] = value;
         CSR_SIZE_DIM3: model_extent[3] = value;
         default: ;
      endcase
   endtask

   // Reprograms all fold registers while the block is idle
   task automatic set_fold(input logic [2:0] kept, input logic [15:0] ext1,
                           input logic [15:0] ext2, input logic [15:0] ext3);
      settle();
      write_reg(CSR_KEPT_DIMS, 16'(kept));
      write_reg(CSR_SIZE_DIM1, ext1);
      write_reg(CSR_SIZE_DIM2, ext2);
      write_reg(CSR_SIZE_DIM3, ext3);
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_item(logic [1:0] action, logic [15:0] c0, logic [15:0] c1,
                                         logic [15:0] c2, logic [15:0] c3,
                                         logic [31:0] value, logic [11:0] slot);
      req_type item;
      item.action      = action;
      item.coord_0     = c0;
      item.coord_1     = c1;
      item.coord_2     = c2;
      item.coord_3     = c3;
      item.entry_value = value;
      item.read_slot   = slot;
      return item;
   endfunction

   function automatic logic [15:0] random_extent();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'd0;
      if (pick == 1) return 16'd1;
      if (pick == 2) return 16'hFFFF;
      if (pick < 7)  return 16'($urandom_range(2, 64));
      return 16'($urandom);
   endfunction

   // Random transaction; most count entries are shaped to land in the store
   function automatic req_type random_item();
      req_type     item;
      logic [15:0] coord [4];
      int unsigned pick, dims, span, prod;
      pick = $urandom_range(0, 99);
      if (pick < 70)      item.action = ACT_COUNT;
      else if (pick < 88) item.action = ACT_READ;
      else if (pick < 98) item.action = ACT_NONE;
      else                item.action = ACT_CLEAR;
      coord[0] = 16'($urandom);
      coord[1] = 16'($urandom);
      coord[2] = 16'($urandom);
      coord[3] = 16'($urandom);
      item.entry_value = $urandom;
      if ($urandom_range(0, 99) < 12)  item.entry_value = 0;
      else if (item.entry_value == 0) item.entry_value = 1;
      item.read_slot = ($urandom_range(0, 1) == 0) ? 12'(last_hit_slot) : 12'($urandom);
      if (item.action == ACT_COUNT && $urandom_range(0, 99) < 75) begin
         if ($urandom_range(0, 99) < 30) begin
            // hit the previous entry's slot again
            coord[0] = last_count_item.coord_0;
            coord[1] = last_count_item.coord_1;
            coord[2] = last_count_item.coord_2;
            coord[3] = last_count_item.coord_3;
         end else begin
            dims = fold_dims();
            prod = 1;
            for (int i = 1; i < dims; i++) begin
               span     = (model_extent[i] == 0) ? 16 :
                          (model_extent[i] > COUNT_DEPTH) ? COUNT_DEPTH : model_extent[i];
               coord[i] = 16'($urandom_range(0, span - 1));
               if (model_extent[i] != 0) prod = prod * span;
               if (prod > COUNT_DEPTH) prod = COUNT_DEPTH + 1;
            end
            coord[0] = (prod >= COUNT_DEPTH) ? 16'd0 :
                       16'($urandom_range(0, COUNT_DEPTH / prod - 1));
         end
      end
      item.coord_0 = coord[0];
      item.coord_1 = coord[1];
      item.coord_2 = coord[2];
      item.coord_3 = coord[3];
      if (item.action == ACT_COUNT) last_count_item = item;
      return item;
   endfunction

   // Reset defaults: two kept dims over 64 columns
   task automatic test_basic_counting();
      send_item(make_item(ACT_COUNT, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'd1, 12'd0));
      send_item(make_item(ACT_COUNT, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF));
      // zero value inside the store: count reported, nothing added
      send_item(make_item(ACT_COUNT, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 12'd0));
      send_item(make_item(ACT_COUNT, 16'd63, 16'd63, 16'd0, 16'd0, 32'h8000_0000, 12'd0));
      // positions past the store
      send_item(make_item(ACT_COUNT, 16'd64, 16'd0, 16'd0, 16'd0, 32'd1, 12'd0));
      send_item(make_item(ACT_COUNT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          32'h7FFF_FFFF, 12'hFFF));
      send_item(make_item(ACT_COUNT, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'd0, 12'd0));
      send_item(make_item(ACT_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd5, 12'd0));
      send_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 12'hFFF));
      send_item(make_item(ACT_NONE, 16'd1, 16'd1, 16'd1, 16'd1, 32'd1, 12'd0));
      send_item(make_item(ACT_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 12'd0));
      send_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 12'd0));
   endtask

   // Kept-dims clamping and extreme extents
   task automatic test_fold_extremes();
      // zero kept dims acts as one
      set_fold(3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(make_item(ACT_COUNT, 16'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd3, 12'd0));
      send_item(make_item(ACT_COUNT, 16'd4096, 16'd0, 16'd0, 16'd0, 32'd3, 12'd0));
      // above four clamps to four; zero extents pass only the coordinate
      set_fold(3'd7, 16'd0, 16'd0, 16'd0);
      send_item(make_item(ACT_COUNT, 16'd4095, 16'd4095, 16'd4095, 16'd4095, 32'd9, 12'd0));
      send_item(make_item(ACT_COUNT, 16'd0, 16'd0, 16'd0, 16'd4096, 32'd9, 12'd0));
      set_fold(3'd4, 16'hFFFF, 16'd1, 16'hFFFF);
      send_item(make_item(ACT_COUNT, 16'd0, 16'd0, 16'd0, 16'd4095, 32'd2, 12'd0));
      send_item(make_item(ACT_COUNT, 16'd0, 16'd1, 16'd0, 16'd0, 32'd2, 12'd0));
      // three dims, top corner and one past it
      set_fold(3'd3, 16'd16, 16'd16, 16'd1);
      send_item(make_item(ACT_COUNT, 16'd15, 16'd15, 16'd15, 16'hFFFF, 32'd4, 12'd0));
      send_item(make_item(ACT_COUNT, 16'd16, 16'd0, 16'd0, 16'd0, 32'd4, 12'd0));
      send_item(make_item(ACT_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 12'hFFF));
   endtask

   // Random traffic under several fold settings and idle profiles
   task automatic test_random_traffic();
      int unsigned idle_pct [3];
      idle_pct = '{36, 64, 0};
      foreach (idle_pct[p]) begin
         repeat (4) begin
            set_fold(3'($urandom_range(0, 7)), random_extent(), random_extent(),
                     random_extent());
            repeat (ITEMS_PER_SETTING) begin
               send_item(random_item());
               if ($urandom_range(0, 99) == 0) settle();
               else                            idle_gap(idle_pct[p]);
            end
         end
      end
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_KEPT_DIMS;
      csr_wdata <= '0;
      foreach (model_counts[i]) model_counts[i] = '0;
      model_kept_dims = RST_KEPT_DIMS;
      model_extent[1] = RST_SIZE_DIM1;
      model_extent[2] = RST_SIZE_DIM2;
      model_extent[3] = RST_SIZE_DIM3;
      last_hit_slot   = 0;
      last_count_item = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_basic_counting();
      test_fold_extremes();
      test_random_traffic();

      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
